>>> sv/boolean_query_score_ranker_top_assert.svh
`ifndef BOOLEAN_QUERY_SCORE_RANKER_TOP_ASSERT_SVH
`define BOOLEAN_QUERY_SCORE_RANKER_TOP_ASSERT_SVH

// same-cycle implication
`define BQSR_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define BQSR_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

>>> sv/bqsr_pkg.sv
package bqsr_pkg;

  localparam int NUM_DOCS_DEF   = 64;
  localparam int SCORE_BITS_DEF = 16;

  localparam int OP_W    = 2;
  localparam int DOC_W   = 6;
  localparam int CNT_W   = 16;
  localparam int TOTAL_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_POSTING  = 2'd0,
    OP_END_WORD = 2'd1,
    OP_OR       = 2'd2,
    OP_END_QRY  = 2'd3
  } op_t;

  typedef struct packed {
    logic wr;
    logic clr;
    logic clr_all;
  } st_ctl_t;

endpackage

>>> sv/bqsr_ifs.sv
interface bqsr_in_if import bqsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [DOC_W-1:0] doc_id;
  logic [CNT_W-1:0] term_count;

  modport source (output valid, op, doc_id, term_count, input ready);
  modport sink   (input valid, op, doc_id, term_count, output ready);
endinterface

interface bqsr_out_if import bqsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DOC_W-1:0]   out_doc;
  logic [CNT_W-1:0]   out_score;
  logic [TOTAL_W-1:0] match_total;
  logic               no_match;
  logic               last_result;

  modport source (output valid, out_doc, out_score, match_total, no_match, last_result,
                  input ready);
  modport sink   (input valid, out_doc, out_score, match_total, no_match, last_result,
                  output ready);
endinterface

>>> sv/bqsr_store.sv
module bqsr_store import bqsr_pkg::*; #(
  parameter int NUM_DOCS   = NUM_DOCS_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF,
  localparam int AW        = (NUM_DOCS > 1) ? $clog2(NUM_DOCS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  st_ctl_t               ctl,
  input  logic [AW-1:0]         wa,
  input  logic [SCORE_BITS-1:0] wd,
  input  logic [AW-1:0]         ra,
  output logic [SCORE_BITS-1:0] rd
);

  logic [SCORE_BITS-1:0] mem [NUM_DOCS];
  logic [NUM_DOCS-1:0]   vld;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wa] <= wd;
    end
    rd <= vld[ra] ? mem[ra] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_all) begin
      vld <= '0;
    end else if (ctl.wr) begin
      vld[wa] <= 1'b1;
    end else if (ctl.clr) begin
      vld[wa] <= 1'b0;
    end
  end

endmodule

>>> sv/boolean_query_score_ranker_top.sv
// Posting beat: written into the word store as it is accepted. End of word and or beats:
// a sweep, one store entry per cycle through the idx/p_idx sweep shared by all modes.
// End of query: a fold of the last group, then one full scan per ranked result plus
// a hand-over, which waits while the output register is full and not taken.
// One beat at a time; a result waits in the output register.
// Reset clears control and the stores' valid bits, so all scores read as zero.
module boolean_query_score_ranker_top import bqsr_pkg::*; #(
  parameter int NUM_DOCS   = NUM_DOCS_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  bqsr_in_if.sink    query,
  bqsr_out_if.source ranked
);

  localparam int AW = (NUM_DOCS > 1) ? $clog2(NUM_DOCS) : 1;
  localparam int CW = (SCORE_BITS > CNT_W) ? SCORE_BITS : CNT_W;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
  localparam logic [AW-1:0] LAST = AW'(NUM_DOCS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_EMIT} state_t;
  typedef enum logic [1:0] {M_WORD, M_FOLD, M_RANK} mode_t;

  state_t                state;
  mode_t                 mode;
  logic                  is_query;
  logic                  started;
  logic                  issuing;
  logic [AW-1:0]         idx;
  logic                  p_vld;
  logic [AW-1:0]         p_idx;
  logic [TOTAL_W-1:0]    total;
  logic [TOTAL_W-1:0]    k;
  logic [AW-1:0]         best;
  logic [SCORE_BITS-1:0] best_score;

  logic                  out_valid;
  logic [DOC_W-1:0]      out_doc;
  logic [CNT_W-1:0]      out_score;
  logic [TOTAL_W-1:0]    match_total;
  logic                  no_match;
  logic                  last_result;

  st_ctl_t               w_ctl, g_ctl, r_ctl;
  logic [AW-1:0]         w_wa, r_wa;
  logic [SCORE_BITS-1:0] w_wd, g_wd, r_wd;
  logic [SCORE_BITS-1:0] w_rd, g_rd, r_rd;

  logic                  accept;
  logic                  in_range;
  logic [CW-1:0]         cnt_ext;
  logic [SCORE_BITS:0]   sum;
  logic                  p_last;
  logic                  emit_go;
  logic [TOTAL_W-1:0]    total_n;
  logic [CW-1:0]         best_ext;

  assign query.ready = (state == S_IDLE);
  assign accept      = query.valid && query.ready;
  assign in_range    = (TOTAL_W'(query.doc_id) < TOTAL_W'(NUM_DOCS));
  assign cnt_ext     = CW'(query.term_count);
  assign sum         = {1'b0, r_rd} + {1'b0, g_rd};
  assign p_last      = p_vld && (p_idx == LAST);
  assign emit_go     = (state == S_EMIT) && (!out_valid || ranked.ready);
  assign total_n     = total + TOTAL_W'(sum[SCORE_BITS-1:0] != '0 || sum[SCORE_BITS]);
  assign best_ext    = CW'(best_score);

  always_comb begin
    w_ctl.wr      = accept && (op_t'(query.op) == OP_POSTING) && in_range;
    w_ctl.clr     = (state == S_SWEEP) && (mode == M_WORD) && p_vld;
    w_ctl.clr_all = (state == S_SWEEP) && (mode == M_FOLD) && p_last && is_query;
    w_wa          = (state == S_IDLE) ? query.doc_id[AW-1:0] : p_idx;
    w_wd          = (cnt_ext > CW'(SCORE_MAX)) ? SCORE_MAX : cnt_ext[SCORE_BITS-1:0];

    g_ctl.wr      = (state == S_SWEEP) && (mode == M_WORD) && p_vld;
    g_ctl.clr     = (state == S_SWEEP) && (mode == M_FOLD) && p_vld;
    g_ctl.clr_all = 1'b0;
    g_wd          = (!started || w_rd < g_rd) ? w_rd : g_rd;

    r_ctl.wr      = (state == S_SWEEP) && (mode == M_FOLD) && p_vld;
    r_ctl.clr     = emit_go && (total != '0);
    r_ctl.clr_all = 1'b0;
    r_wa          = (state == S_EMIT) ? best : p_idx;
    r_wd          = sum[SCORE_BITS] ? SCORE_MAX : sum[SCORE_BITS-1:0];
  end

  bqsr_store #(.NUM_DOCS(NUM_DOCS), .SCORE_BITS(SCORE_BITS)) u_word (
    .clk(clk), .rst(rst), .ctl(w_ctl), .wa(w_wa), .wd(w_wd), .ra(idx), .rd(w_rd)
  );

  bqsr_store #(.NUM_DOCS(NUM_DOCS), .SCORE_BITS(SCORE_BITS)) u_group (
    .clk(clk), .rst(rst), .ctl(g_ctl), .wa(p_idx), .wd(g_wd), .ra(idx), .rd(g_rd)
  );

  bqsr_store #(.NUM_DOCS(NUM_DOCS), .SCORE_BITS(SCORE_BITS)) u_result (
    .clk(clk), .rst(rst), .ctl(r_ctl), .wa(r_wa), .wd(r_wd), .ra(idx), .rd(r_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= M_WORD;
      is_query   <= 1'b0;
      started    <= 1'b0;
      issuing    <= 1'b0;
      idx        <= '0;
      p_vld      <= 1'b0;
      p_idx      <= '0;
      total      <= '0;
      k          <= '0;
      best       <= '0;
      best_score <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ranked.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && op_t'(query.op) != OP_POSTING) begin
            state    <= S_SWEEP;
            mode     <= (op_t'(query.op) == OP_END_WORD) ? M_WORD : M_FOLD;
            is_query <= (op_t'(query.op) == OP_END_QRY);
            idx      <= '0;
            issuing  <= 1'b1;
            p_vld    <= 1'b0;
            total    <= '0;
          end
        end
        S_SWEEP: begin
          if (issuing) begin
            idx <= idx + AW'(1);
            if (idx == LAST) begin
              issuing <= 1'b0;
            end
          end
          p_vld <= issuing;
          p_idx <= idx;
          if (p_vld) begin
            unique case (mode)
              M_FOLD: total <= total_n;
              M_RANK: begin
                if (r_rd > best_score) begin
                  best       <= p_idx;
                  best_score <= r_rd;
                end
              end
              default: ;
            endcase
          end
          if (p_last) begin
            p_vld <= 1'b0;
            unique case (mode)
              M_WORD: begin
                started <= 1'b1;
                state   <= S_IDLE;
              end
              M_FOLD: begin
                started <= 1'b0;
                if (is_query) begin
                  mode       <= M_RANK;
                  idx        <= '0;
                  issuing    <= 1'b1;
                  k          <= '0;
                  best       <= '0;
                  best_score <= '0;
                end else begin
                  state <= S_IDLE;
                end
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        default: begin
          if (emit_go) begin
            out_valid   <= 1'b1;
            out_doc     <= (total == '0) ? '0 : DOC_W'(best);
            out_score   <= (total == '0) ? '0 : best_ext[CNT_W-1:0];
            match_total <= total;
            no_match    <= (total == '0);
            last_result <= (total == '0) || (TOTAL_W'(k + TOTAL_W'(1)) == total);
            k           <= k + TOTAL_W'(1);
            if ((total == '0) || (TOTAL_W'(k + TOTAL_W'(1)) == total)) begin
              state <= S_IDLE;
            end else begin
              state      <= S_SWEEP;
              idx        <= '0;
              issuing    <= 1'b1;
              best       <= '0;
              best_score <= '0;
            end
          end
        end
      endcase
    end
  end

  assign ranked.valid       = out_valid;
  assign ranked.out_doc     = out_doc;
  assign ranked.out_score   = out_score;
  assign ranked.match_total = match_total;
  assign ranked.no_match    = no_match;
  assign ranked.last_result = last_result;

endmodule

>>> sv/bqsr_checker.sv
`include "boolean_query_score_ranker_top_assert.svh"

module bqsr_checker import bqsr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DOC_W-1:0]   out_doc,
  input logic [CNT_W-1:0]   out_score,
  input logic [TOTAL_W-1:0] match_total,
  input logic               no_match,
  input logic               last_result
);

  `BQSR_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_doc) && $stable(out_score) && $stable(last_result), "stalled beat changed")
  `BQSR_ASSERT_IMP(a_none, clk, rst, out_valid && no_match, last_result && out_doc == '0 && out_score == '0 && match_total == '0, "malformed no-match beat")
  `BQSR_ASSERT_IMP(a_total, clk, rst, out_valid && !no_match, match_total != '0, "match beat with zero total")
  `BQSR_ASSERT_NXT(a_busy, clk, rst, out_valid && out_ready && !last_result, !in_ready || (out_valid && last_result), "input taken mid-ranking")

endmodule

bind boolean_query_score_ranker_top bqsr_checker u_bqsr_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(query.ready),
  .out_valid(ranked.valid),
  .out_ready(ranked.ready),
  .out_doc(ranked.out_doc),
  .out_score(ranked.out_score),
  .match_total(ranked.match_total),
  .no_match(ranked.no_match),
  .last_result(ranked.last_result)
);
